>>> src/sitda_pkg.sv
// Shared constants for the signed integer to decimal ASCII converter.
package sitda_pkg;

  localparam int unsigned MAG_W  = 32;
  localparam int unsigned CHAR_W = 7;
  localparam int unsigned DIG_W  = 4;

  // Quotient bits left after the reciprocal shift: 32 - 3.
  localparam int unsigned QUO_W  = 29;
  localparam int unsigned SHIFT  = 35;

  // ceil(2^35 / 10): exact division by ten for any 32-bit magnitude
  localparam logic [MAG_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;

  localparam logic [CHAR_W-1:0] CH_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'd48;

endpackage

>>> src/signed_int_to_decimal_ascii_core.sv
// Top level of the signed 32-bit integer to decimal ASCII converter.
//
// Each input transaction carries one signed 32-bit number; the block returns its decimal
// text one ASCII character per output transaction: a leading '-' for negative numbers,
// then the significant digits, most significant first, with tlast on the final digit.
// Zero prints as a single '0', and -2147483648 prints in full. A row of MAX_DIGITS cells
// splits off one decimal digit each by a reciprocal multiply, registering the number in
// every cell, and a new number can enter every cycle while the chain is not stalled. The
// character emitter then sends one character per cycle while the output is ready, so a
// number holds the output for its sign and its digits, and the output channel sets the
// sustained rate. Only the low MAX_DIGITS decimal digits of a magnitude are printed.
module signed_int_to_decimal_ascii_core
  import sitda_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] number
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [6:0] char_code, [7] zero fill
  output logic        out_tlast   // last_char
);

  localparam int unsigned IDXW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic                             ch_valid  [MAX_DIGITS+1];
  logic                             ch_ready  [MAX_DIGITS+1];
  logic                             ch_neg    [MAX_DIGITS+1];
  logic [MAG_W-1:0]                 ch_mag    [MAX_DIGITS+1];
  logic [MAX_DIGITS-1:0][DIG_W-1:0] ch_digits [MAX_DIGITS+1];
  logic [IDXW-1:0]                  ch_top    [MAX_DIGITS+1];
  logic [CHAR_W-1:0]                char_code;

  // Feed the chain with sign and magnitude
  assign ch_valid[0]  = in_tvalid;
  assign ch_neg[0]    = in_tdata[MAG_W-1];
  assign ch_mag[0]    = in_tdata[MAG_W-1] ? (~in_tdata + 32'd1) : in_tdata;
  assign ch_digits[0] = '0;
  assign ch_top[0]    = '0;

  assign in_tready = ch_ready[0];

  // Digit cells, least significant position first
  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    sitda_cell #(
      .MAX_DIGITS (MAX_DIGITS),
      .POS        (i),
      .IDXW       (IDXW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .up_valid  (ch_valid[i]),
      .up_ready  (ch_ready[i]),
      .up_neg    (ch_neg[i]),
      .up_mag    (ch_mag[i]),
      .up_digits (ch_digits[i]),
      .up_top    (ch_top[i]),
      .dn_valid  (ch_valid[i+1]),
      .dn_ready  (ch_ready[i+1]),
      .dn_neg    (ch_neg[i+1]),
      .dn_mag    (ch_mag[i+1]),
      .dn_digits (ch_digits[i+1]),
      .dn_top    (ch_top[i+1])
    );
  end

  sitda_emit #(
    .MAX_DIGITS (MAX_DIGITS),
    .IDXW       (IDXW)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (ch_valid[MAX_DIGITS]),
    .up_ready  (ch_ready[MAX_DIGITS]),
    .up_neg    (ch_neg[MAX_DIGITS]),
    .up_digits (ch_digits[MAX_DIGITS]),
    .up_top    (ch_top[MAX_DIGITS]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (char_code),
    .out_last  (out_tlast)
  );

  assign out_tdata = {1'b0, char_code};

endmodule

>>> src/sitda_cell.sv
// One digit cell: splits off a decimal digit and hands the quotient to the next cell.
module sitda_cell
  import sitda_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 10,
  parameter int unsigned POS        = 0,
  parameter int unsigned IDXW       = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  logic                              up_neg,
  input  logic [MAG_W-1:0]                  up_mag,
  input  logic [MAX_DIGITS-1:0][DIG_W-1:0]  up_digits,
  input  logic [IDXW-1:0]                   up_top,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output logic                              dn_neg,
  output logic [MAG_W-1:0]                  dn_mag,
  output logic [MAX_DIGITS-1:0][DIG_W-1:0]  dn_digits,
  output logic [IDXW-1:0]                   dn_top
);

  logic                             valid_r;
  logic                             neg_r;
  logic [MAG_W-1:0]                 mag_r;
  logic [MAX_DIGITS-1:0][DIG_W-1:0] digits_r;
  logic [IDXW-1:0]                  top_r;

  logic [2*MAG_W-1:0]               prod;
  logic [QUO_W-1:0]                 quo;
  logic [MAG_W-1:0]                 quo_x10;
  logic [MAG_W-1:0]                 rem;
  logic [DIG_W-1:0]                 digit;
  logic [MAX_DIGITS-1:0][DIG_W-1:0] digits_nxt;
  logic [IDXW-1:0]                  top_nxt;

  // Divide by ten through the reciprocal; remainder by shift-add and subtract
  always_comb begin
    prod    = {{MAG_W{1'b0}}, up_mag} * {{MAG_W{1'b0}}, RECIP_TEN};
    quo     = prod[2*MAG_W-1:SHIFT];
    quo_x10 = {quo, 3'b000} + {2'b00, quo, 1'b0};
    rem     = up_mag - quo_x10;
    digit   = rem[DIG_W-1:0];
  end

  // Record this position's digit and track the highest nonzero position
  always_comb begin
    digits_nxt      = up_digits;
    digits_nxt[POS] = digit;
    top_nxt         = (digit != '0) ? IDXW'(POS) : up_top;
  end

  assign up_ready = !valid_r || dn_ready;

  // Hold, advance or drain the cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      neg_r    <= up_neg;
      mag_r    <= {{(MAG_W-QUO_W){1'b0}}, quo};
      digits_r <= digits_nxt;
      top_r    <= top_nxt;
    end
  end

  assign dn_valid  = valid_r;
  assign dn_neg    = neg_r;
  assign dn_mag    = mag_r;
  assign dn_digits = digits_r;
  assign dn_top    = top_r;

endmodule

>>> src/sitda_emit.sv
// Character emitter: sends the sign and the significant digits of one number.
module sitda_emit
  import sitda_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 10,
  parameter int unsigned IDXW       = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  logic                              up_neg,
  input  logic [MAX_DIGITS-1:0][DIG_W-1:0]  up_digits,
  input  logic [IDXW-1:0]                   up_top,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [CHAR_W-1:0]                 out_char,
  output logic                              out_last
);

  logic                             busy_r;
  logic                             sign_r;
  logic [IDXW-1:0]                  pos_r;
  logic [MAX_DIGITS-1:0][DIG_W-1:0] digits_r;
  logic                             take;

  // Current character: sign first, then digits from the top down
  always_comb begin
    out_char = sign_r ? CH_MINUS
                      : CH_ZERO + {{(CHAR_W-DIG_W){1'b0}}, digits_r[pos_r]};
    out_last = !sign_r && (pos_r == '0);
  end

  assign out_valid = busy_r;
  assign take      = busy_r && out_ready;
  assign up_ready  = !busy_r || (take && out_last);

  // Load a new number or step through the current one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sign_r <= 1'b0;
    end else if (up_ready) begin
      busy_r <= up_valid;
      sign_r <= up_valid && up_neg;
    end else if (take && sign_r) begin
      sign_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      digits_r <= up_digits;
      pos_r    <= up_top;
    end else if (take && !sign_r) begin
      pos_r    <= pos_r - IDXW'(1);
    end
  end

endmodule
